// ----- hdl/ttps_pkg.sv -----
package ttps_pkg;

    // Field widths of one item and one result.
    localparam int KEY_W   = 64;
    localparam int PLY_W   = 7;
    localparam int DEPTH_W = 7;
    localparam int SCORE_W = 17;
    localparam int KIND_W  = 2;
    localparam int THR_W   = 16;

    // Request codes carried in s_tuser.
    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    // Bound kinds of a stored entry.
    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

    localparam logic [THR_W-1:0] MATE_THR_RESET = 16'd48000;

    // Stream packing, lowest bit first.
    localparam int S_KEY_LSB   = 0;
    localparam int S_PLY_LSB   = S_KEY_LSB + KEY_W;
    localparam int S_DEPTH_LSB = S_PLY_LSB + PLY_W;
    localparam int S_ALPHA_LSB = S_DEPTH_LSB + DEPTH_W;
    localparam int S_BETA_LSB  = S_ALPHA_LSB + SCORE_W;
    localparam int S_SCORE_LSB = S_BETA_LSB + SCORE_W;
    localparam int S_TDATA_W   = 136;
    localparam int U_REQ_BIT   = 0;
    localparam int U_KIND_LSB  = 1;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 24;

    // Result queue.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    // One table entry as held in memory.
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic                      valid;
        logic [DEPTH_W-1:0]        depth;
        logic [KIND_W-1:0]         kind;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    // One request after unpacking from the input stream.
    typedef struct packed {
        logic                      req_type;
        logic [KEY_W-1:0]          key;
        logic [PLY_W-1:0]          ply;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic [KIND_W-1:0]         kind;
        logic signed [SCORE_W-1:0] score;
    } req_t;

    // One result item.
    typedef struct packed {
        logic                      hit;
        logic signed [SCORE_W-1:0] score;
    } result_t;

endpackage

// ----- hdl/ttps_ram.sv -----
module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the contents from before a write in the same cycle.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/ttps_score.sv -----
module ttps_score
    import ttps_pkg::*;
(
    input  req_t             req,
    input  entry_t           entry,
    input  logic [THR_W-1:0] mate_thr,
    output result_t          result,
    output entry_t           wr_entry
);

    // Mate scores move by ply: away from the root when stored, back toward it
    // when read. The two checks are chained and the sum is clamped to 17 bits.
    function automatic logic [SCORE_W-1:0] mate_adjust(
        input logic [SCORE_W-1:0] score,
        input logic [PLY_W-1:0]   ply,
        input logic [THR_W-1:0]   thr,
        input logic               away
    );
        logic signed [SCORE_W+1:0] s;
        logic signed [SCORE_W+1:0] p;
        logic signed [SCORE_W+1:0] t;
        s = $signed({{2{score[SCORE_W-1]}}, score});
        p = $signed({{(SCORE_W+2-PLY_W){1'b0}}, ply});
        t = $signed({{(SCORE_W+2-THR_W){1'b0}}, thr});
        if (s < -t) begin
            s = away ? s - p : s + p;
        end
        if (s > t) begin
            s = away ? s + p : s - p;
        end
        if (s < -19'sd65536) begin
            s = -19'sd65536;
        end else if (s > 19'sd65535) begin
            s = 19'sd65535;
        end
        return s[SCORE_W-1:0];
    endfunction

    logic [SCORE_W-1:0] probe_s;
    logic [SCORE_W-1:0] store_s;
    logic               match;

    always_comb begin
        probe_s = mate_adjust(entry.score, req.ply, mate_thr, 1'b0);
        store_s = mate_adjust(req.score, req.ply, mate_thr, 1'b1);
        match   = entry.valid && (entry.key == req.key) && (entry.depth >= req.depth);

        result = '0;
        if (req.req_type == REQ_PROBE && match) begin
            case (entry.kind)
                KIND_EXACT: begin
                    result.hit   = 1'b1;
                    result.score = probe_s;
                end
                KIND_UPPER: begin
                    if ($signed(probe_s) <= $signed(req.alpha)) begin
                        result.hit   = 1'b1;
                        result.score = req.alpha;
                    end
                end
                KIND_LOWER: begin
                    if ($signed(probe_s) >= $signed(req.beta)) begin
                        result.hit   = 1'b1;
                        result.score = req.beta;
                    end
                end
                default: begin
                end
            endcase
        end

        wr_entry.key   = req.key;
        wr_entry.valid = 1'b1;
        wr_entry.depth = req.depth;
        wr_entry.kind  = req.kind;
        wr_entry.score = store_s;
    end

endmodule

// ----- hdl/ttps_outq.sv -----
module ttps_outq
    import ttps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  result_t               push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_data,
    output logic [OUTQ_CNT_W-1:0] count
);

    result_t               slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    // The caller only pushes when a slot is free.
    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ----- hdl/transposition_table_probe_store.sv -----
// Direct-mapped transposition table with probe and store requests.
// Each input item on the s_ channel is a probe or a store, selected by
// s_tuser bit 0. The table slot is the low log2(TABLE_ENTRIES) bits of the
// 64-bit key, so TABLE_ENTRIES must be a power of two. Every item, probe or
// store, yields exactly one result item on the m_ channel, in order; a store
// and a missed probe return hit 0 with a zero score.
// An accepted item passes through the stage-one register and then the
// result queue, which raises m_tvalid. The table lives in one memory with a
// registered read; the entry is read in the accept cycle and the store is
// written back in the next one, with a one-deep forward covering a
// back-to-back access to the same slot. One item per cycle is sustained as
// long as the receiver keeps up.
// Results wait in a four-item queue. s_tready drops when queued results plus
// the item in flight fill that queue, so a stalled receiver holds the input
// side back and nothing is lost.
// After reset the block sweeps the memory once, one slot per cycle, to
// clear all valid bits; s_tready stays low until the sweep ends.
// The mate threshold register resets to 48000 and may be written through
// cfg_wr_en/cfg_wr_data only while no item is in flight.
module transposition_table_probe_store
    import ttps_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: mate threshold.
    input  logic                 cfg_wr_en,
    input  logic [THR_W-1:0]     cfg_wr_data,
    // Requests.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // position_key, current_ply, search_depth, alpha_bound, beta_bound,
    // store_score, then zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type, bound_kind.
    input  logic [S_TUSER_W-1:0] s_tuser,
    // Results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // probe_score, then zero padding.
    output logic [M_TDATA_W-1:0] m_tdata,
    // hit.
    output logic                 m_tuser
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = $bits(entry_t);

    // Configuration register.
    logic [THR_W-1:0] mate_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mate_thr_reg <= MATE_THR_RESET;
        end else if (cfg_wr_en) begin
            mate_thr_reg <= cfg_wr_data;
        end
    end

    // Clearing sweep after reset: writes an all-zero entry to every slot.
    logic             clr_active_reg, clr_active_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg) begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    // Unpack the incoming request.
    req_t req_in;

    always_comb begin
        req_in.req_type = s_tuser[U_REQ_BIT];
        req_in.kind     = s_tuser[U_KIND_LSB +: KIND_W];
        req_in.key      = s_tdata[S_KEY_LSB +: KEY_W];
        req_in.ply      = s_tdata[S_PLY_LSB +: PLY_W];
        req_in.depth    = s_tdata[S_DEPTH_LSB +: DEPTH_W];
        req_in.alpha    = s_tdata[S_ALPHA_LSB +: SCORE_W];
        req_in.beta     = s_tdata[S_BETA_LSB +: SCORE_W];
        req_in.score    = s_tdata[S_SCORE_LSB +: SCORE_W];
    end

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // Stage one: the entry read in the accept cycle is available here.
    logic   st1_valid_reg;
    req_t   st1_req_reg;
    logic   fwd_hit_reg;
    entry_t fwd_entry_reg;
    entry_t wr_entry;
    logic   st1_store;
    logic   same_slot;

    assign st1_store = st1_valid_reg && (st1_req_reg.req_type == REQ_STORE);
    assign same_slot = (req_in.key[IDX_W-1:0] == st1_req_reg.key[IDX_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= s_accept;
            // The memory returns the old entry when a store to the same slot
            // is written in the very cycle the next item reads it.
            fwd_hit_reg   <= s_accept && st1_store && same_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_req_reg <= req_in;
        end
        fwd_entry_reg <= wr_entry;
    end

    // Table memory.
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t             entry_cur;

    always_comb begin
        if (clr_active_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = st1_store;
            ram_wr_addr = st1_req_reg.key[IDX_W-1:0];
            ram_wr_data = wr_entry;
        end
        entry_cur = fwd_hit_reg ? fwd_entry_reg : entry_t'(ram_rd_data);
    end

    ttps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (req_in.key[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Score adjustment, hit decision and the entry to write on a store.
    result_t st1_result;

    ttps_score u_score (
        .req      (st1_req_reg),
        .entry    (entry_cur),
        .mate_thr (mate_thr_reg),
        .result   (st1_result),
        .wr_entry (wr_entry)
    );

    // Result queue and input flow control.
    result_t               q_out;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0]   q_pending;

    ttps_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (st1_valid_reg),
        .push_data (st1_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_out),
        .count     (q_count)
    );

    // Accept only when the queue has room for this item and the one in flight.
    assign q_pending = (OUTQ_CNT_W+1)'(q_count) + (OUTQ_CNT_W+1)'(st1_valid_reg);
    assign s_tready  = !clr_active_reg && (q_pending < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

    assign m_tdata = {{(M_TDATA_W-SCORE_W){1'b0}}, q_out.score};
    assign m_tuser = q_out.hit;

endmodule

// ----- verif/transposition_table_probe_store_tb.sv -----
`timescale 1ns / 100ps

module transposition_table_probe_store_tb;

    import ttps_pkg::*;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int POOL_SIZE     = 32;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 90;

    // The package names three bound kinds; the fourth encoding is legal on a
    // store and must make any later probe of that entry miss.
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    // One row of the directed table. Scores and bounds are plain integers so
    // that negative values read naturally; they are cut to 17 bits on use.
    // When typed is set, the expected result is the one written in the row.
    typedef struct {
        logic              req;
        logic [KEY_W-1:0]  key;
        int                ply;
        int                depth;
        int                alpha;
        int                beta;
        logic [KIND_W-1:0] kind;
        int                score;
        bit                typed;
        logic              want_hit;
        int                want_score;
    } vector_t;

    // Directed rows, all under the reset mate threshold of 48000. Every probe
    // targets a slot that an earlier row has stored.
    vector_t directed_rows [25] = '{
        // Plain exact entry, then a hit, a depth miss and a key miss on slot 0.
        '{REQ_STORE, 64'h0, 0, 10, 0, 0, KIND_EXACT, 100, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h0, 0, 10, -65536, 65535, KIND_EXACT, 0, 1'b1, 1'b1, 100},
        '{REQ_PROBE, 64'h0, 0, 11, 0, 0, KIND_EXACT, 0, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'hFFFF_FFFF_FFFF_F000, 0, 0, 0, 0, KIND_EXACT, 0,
          1'b1, 1'b0, 0},
        // Largest key, ply, depth and score: the stored mate saturates.
        '{REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 127, 127, 0, 0, KIND_EXACT, 65535,
          1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 127, 127, 0, 0, KIND_EXACT, 0,
          1'b0, 1'b0, 0},
        // Most negative score saturates on the way in.
        '{REQ_STORE, 64'h1, 127, 0, 0, 0, KIND_EXACT, -65536, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h1, 0, 0, 0, 0, KIND_EXACT, 0, 1'b1, 1'b1, -65536},
        '{REQ_PROBE, 64'h1, 50, 0, 0, 0, KIND_EXACT, 0, 1'b0, 1'b0, 0},
        // Upper bound: usable only at or below alpha.
        '{REQ_STORE, 64'h2, 3, 5, 0, 0, KIND_UPPER, -200, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h2, 3, 5, -200, 0, KIND_EXACT, 0, 1'b1, 1'b1, -200},
        '{REQ_PROBE, 64'h2, 3, 5, -201, 0, KIND_EXACT, 0, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h2, 3, 5, 65535, 0, KIND_EXACT, 0, 1'b1, 1'b1, 65535},
        // Lower bound: usable only at or above beta.
        '{REQ_STORE, 64'h3, 3, 5, 0, 0, KIND_LOWER, 300, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h3, 3, 5, 0, 300, KIND_EXACT, 0, 1'b1, 1'b1, 300},
        '{REQ_PROBE, 64'h3, 3, 5, 0, 301, KIND_EXACT, 0, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h3, 3, 5, 0, -65536, KIND_EXACT, 0, 1'b1, 1'b1, -65536},
        // Reserved kind is stored but never hits.
        '{REQ_STORE, 64'h4, 0, 5, 0, 0, KIND_RESERVED, 5, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h4, 0, 5, -65536, 65535, KIND_EXACT, 0, 1'b1, 1'b0, 0},
        // Just above the threshold is a mate and moves with ply; the
        // threshold itself is not a mate.
        '{REQ_STORE, 64'h5, 20, 9, 0, 0, KIND_EXACT, 48001, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h5, 5, 9, 0, 0, KIND_EXACT, 0, 1'b0, 1'b0, 0},
        '{REQ_STORE, 64'h5, 20, 9, 0, 0, KIND_EXACT, 48000, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h5, 5, 9, 0, 0, KIND_EXACT, 0, 1'b1, 1'b1, 48000},
        // Negative mate on the other side of the threshold.
        '{REQ_STORE, 64'h6, 30, 9, 0, 0, KIND_EXACT, -48001, 1'b1, 1'b0, 0},
        '{REQ_PROBE, 64'h6, 1, 9, 0, 0, KIND_EXACT, 0, 1'b0, 1'b0, 0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [THR_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // position_key, current_ply, search_depth, alpha_bound, beta_bound,
    // store_score, then zero padding.
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // req_type, bound_kind.
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // probe_score, then zero padding.
    logic [M_TDATA_W-1:0] m_tdata;
    // hit.
    logic                 m_tuser;

    // Shadow copy of the table and of the mate threshold, advanced once per
    // accepted request and once per register write.
    entry_t           slot_mirror [TABLE_ENTRIES];
    logic [THR_W-1:0] mate_thr_mirror = MATE_THR_RESET;

    // Results still owed by the block, oldest first.
    result_t pending_results [$];

    // Keys used by the random part. Many share a few slots so that entries
    // get overwritten and probes collide on the slot with a different key.
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int mismatches = 0;
    // A nonzero value is taken by the result side as the length of its next stall.
    int hold_request = 0;

    transposition_table_probe_store #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Scores are held to the 17-bit signed range after every mate adjustment.
    function automatic int saturate_score(input int s);
        if (s < -65536) begin
            return -65536;
        end
        if (s > 65535) begin
            return 65535;
        end
        return s;
    endfunction

    // Applies one request to the shadow table and returns the result that the
    // block owes for it. A store always answers with a miss and a zero score.
    function automatic result_t table_access(input req_t r);
        result_t          res;
        entry_t           e;
        logic [SLOT_W-1:0] slot;
        int               s;
        int               thr;
        int               ply_i;
        res   = '0;
        thr   = int'(mate_thr_mirror);
        ply_i = int'(r.ply);
        slot  = r.key[SLOT_W-1:0];
        if (r.req_type == REQ_STORE) begin
            // Mate scores are stored relative to the node, not the root.
            s = int'(r.score);
            if (s < -thr) begin
                s = s - ply_i;
            end
            if (s > thr) begin
                s = s + ply_i;
            end
            s = saturate_score(s);
            e.key   = r.key;
            e.valid = 1'b1;
            e.depth = r.depth;
            e.kind  = r.kind;
            e.score = s[SCORE_W-1:0];
            slot_mirror[slot] = e;
        end else begin
            e = slot_mirror[slot];
            if (e.valid && e.key == r.key && e.depth >= r.depth) begin
                // The two mate checks run in sequence, the second one on the
                // output of the first.
                s = int'(e.score);
                if (s < -thr) begin
                    s = s + ply_i;
                end
                if (s > thr) begin
                    s = s - ply_i;
                end
                s = saturate_score(s);
                case (e.kind)
                    KIND_EXACT: begin
                        res.hit   = 1'b1;
                        res.score = s[SCORE_W-1:0];
                    end
                    KIND_UPPER: begin
                        if (s <= int'(r.alpha)) begin
                            res.hit   = 1'b1;
                            res.score = r.alpha;
                        end
                    end
                    KIND_LOWER: begin
                        if (s >= int'(r.beta)) begin
                            res.hit   = 1'b1;
                            res.score = r.beta;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        return res;
    endfunction

    // Scores for random stores: full range, close to either mate threshold,
    // or ordinary small evaluations.
    function automatic int random_score();
        int offset;
        offset = int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 3))
            0: return int'($urandom);
            1: return int'(mate_thr_mirror) + offset;
            2: return -int'(mate_thr_mirror) + offset;
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // Builds one random request. Probes only go to slots that hold an entry,
    // and their depth and window are often placed close to that entry.
    function automatic req_t random_request();
        req_t   r;
        entry_t e;
        int     stored_idx [$];
        int     d;
        logic [SLOT_W-1:0] slot;
        foreach (key_pool[i]) begin
            if (slot_mirror[key_pool[i][SLOT_W-1:0]].valid) begin
                stored_idx.push_back(i);
            end
        end
        r.ply   = PLY_W'($urandom_range(0, 127));
        r.kind  = KIND_W'($urandom_range(0, 3));
        r.alpha = SCORE_W'($urandom);
        r.beta  = SCORE_W'($urandom);
        if (stored_idx.size() == 0 || $urandom_range(0, 99) < 40) begin
            r.req_type = REQ_STORE;
            r.key      = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            r.depth    = DEPTH_W'($urandom_range(0, 127));
            r.score    = SCORE_W'(random_score());
        end else begin
            r.req_type = REQ_PROBE;
            r.key      = key_pool[stored_idx[$urandom_range(0, stored_idx.size() - 1)]];
            slot       = r.key[SLOT_W-1:0];
            // Now and then the same slot with a foreign key.
            if ($urandom_range(0, 4) == 0) begin
                r.key             = {$urandom, $urandom};
                r.key[SLOT_W-1:0] = slot;
            end
            e = slot_mirror[slot];
            if ($urandom_range(0, 1) == 1) begin
                r.depth = DEPTH_W'($urandom_range(0, 127));
            end else begin
                d = int'(e.depth) + int'($urandom_range(0, 3)) - 2;
                r.depth = DEPTH_W'((d < 0) ? 0 : ((d > 127) ? 127 : d));
            end
            if ($urandom_range(0, 1) == 1) begin
                r.alpha = SCORE_W'(int'(e.score) + int'($urandom_range(0, 6)) - 3);
                r.beta  = SCORE_W'(int'(e.score) + int'($urandom_range(0, 6)) - 3);
            end
            r.score = SCORE_W'($urandom);
        end
        return r;
    endfunction

    // Drops s_tvalid for a gap of the given length. A zero gap leaves the
    // valid line alone so the next item follows in the very next cycle.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Presents one request and holds it until the block takes it; the result
    // owed for it is queued at the edge of acceptance.
    task automatic offer_request(input req_t r, input result_t owed);
        logic [S_TDATA_W-1:0] d;
        logic [S_TUSER_W-1:0] u;
        d = '0;
        d[S_KEY_LSB   +: KEY_W]   = r.key;
        d[S_PLY_LSB   +: PLY_W]   = r.ply;
        d[S_DEPTH_LSB +: DEPTH_W] = r.depth;
        d[S_ALPHA_LSB +: SCORE_W] = r.alpha;
        d[S_BETA_LSB  +: SCORE_W] = r.beta;
        d[S_SCORE_LSB +: SCORE_W] = r.score;
        u = '0;
        u[U_REQ_BIT]             = r.req_type;
        u[U_KIND_LSB +: KIND_W]  = r.kind;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= u;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(owed);
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // The threshold may only change with nothing in flight, so the pipeline
    // is drained first.
    task automatic write_mate_threshold(input logic [THR_W-1:0] value);
        drain_results();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en       <= 1'b0;
        mate_thr_mirror  = value;
    endtask

    // Main stimulus: reset, directed rows, then random phases under several
    // thresholds, with the extremes 0 and 65535 among them.
    initial begin : stimulus
        req_t             r;
        result_t          owed;
        vector_t          row;
        logic [THR_W-1:0] phase_thr [RANDOM_PHASES];
        bit               burst;
        int               gap;

        foreach (slot_mirror[i]) begin
            slot_mirror[i] = '0;
        end
        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom, $urandom};
            if (i < 20) begin
                key_pool[i][SLOT_W-1:0] = SLOT_W'(12'h100 + (i % 6));
            end
        end
        phase_thr = '{16'd65535, 16'd0, 16'd300, 16'd0, 16'd48000};
        phase_thr[3] = THR_W'($urandom_range(1, 65534));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // The block clears its valid bits after reset with s_tready low;
        // the first offer simply waits that sweep out.
        foreach (directed_rows[i]) begin
            row        = directed_rows[i];
            r.req_type = row.req;
            r.key      = row.key;
            r.ply      = PLY_W'(row.ply);
            r.depth    = DEPTH_W'(row.depth);
            r.alpha    = SCORE_W'(row.alpha);
            r.beta     = SCORE_W'(row.beta);
            r.kind     = row.kind;
            r.score    = SCORE_W'(row.score);
            owed = table_access(r);
            if (row.typed) begin
                owed.hit   = row.want_hit;
                owed.score = SCORE_W'(row.want_score);
            end
            idle_sender(int'($urandom_range(0, 10)));
            offer_request(r, owed);
        end

        burst = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_mate_threshold(phase_thr[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // In the first phase the result side stalls for a long time
                // while items keep coming back to back, so the result queue
                // fills and the block has to push back on its input.
                if (p == 0 && n == 0) begin
                    hold_request = 80;
                end
                if (n % 15 == 0) begin
                    burst = ($urandom_range(0, 3) == 0);
                end
                gap = (burst || (p == 0 && n < 24)) ? 0 : int'($urandom_range(0, 10));
                idle_sender(gap);
                r = random_request();
                offer_request(r, table_access(r));
            end
        end

        drain_results();
        // Keep the clock running to catch any result the block should not send.
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: may stall before each item, with stretches of no stalling,
    // and compares each item with the oldest owed result.
    initial begin : result_sink
        result_t got;
        result_t want;
        int      stall;
        int      taken;
        bit      sink_burst;
        taken      = 0;
        sink_burst = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = sink_burst ? 0 : int'($urandom_range(0, 10));
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            if (taken % 16 == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            got.hit   = m_tuser;
            got.score = m_tdata[SCORE_W-1:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none got hit %0b score %0d",
                         $time, got.hit, $signed(got.score));
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b got %0b",
                             $time, want.hit, got.hit);
                    mismatches++;
                end
                if (got.score !== want.score) begin
                    $display("%0t: probe_score mismatch, expected %0d got %0d",
                             $time, $signed(want.score), $signed(got.score));
                    mismatches++;
                end
            end
        end
    end

    // Safety net: a correct run needs well under a tenth of this time.
    initial begin : watchdog
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
